// ===== rtl/stochastic_lattice_competition_step_macros.svh =====
// Assertion macros shared by the lattice competition step RTL.
`ifndef STOCHASTIC_LATTICE_COMPETITION_STEP_MACROS_SVH
`define STOCHASTIC_LATTICE_COMPETITION_STEP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i and switched off during reset.
`define SLCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slcs assertion failed");
// Next-cycle implication, sampled on clk_i and switched off during reset.
`define SLCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slcs assertion failed");
`else
`define SLCS_ASSERT_IMP(lbl, ante, cons)
`define SLCS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/slcs_pkg.sv =====
// Types, constants and codes shared by the lattice competition step.
package slcs_pkg;

  // Field widths.
  localparam int unsigned TypeW    = 2;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned SizeW    = 11;
  localparam int unsigned FitW     = 17;
  localparam int unsigned RandW    = 16;
  localparam int unsigned OffW     = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  // Lattice limits.
  localparam int unsigned DefMaxCells = 1024;
  localparam int unsigned MinCells    = 4;

  // One bit of the cell index is brought in per division step.
  localparam int unsigned DivSteps = IdxW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // Register reset values.
  localparam logic [SizeW-1:0] RstLatticeSize = SizeW'(1024);
  localparam logic [IdxW-1:0]  RstLeftEdge    = IdxW'(256);
  localparam logic [IdxW-1:0]  RstRightEdge   = IdxW'(768);
  localparam logic [FitW-1:0]  RstFitness1    = FitW'(49480);
  localparam logic [FitW-1:0]  RstFitness2    = FitW'(65536);
  localparam logic [FitW-1:0]  RstFitness3    = FitW'(45875);
  localparam logic [RandW-1:0] RstMutThresh   = RandW'(1809);

  // Strain type codes.
  localparam logic [TypeW-1:0] TYPE_1 = 2'd1;
  localparam logic [TypeW-1:0] TYPE_2 = 2'd2;
  localparam logic [TypeW-1:0] TYPE_3 = 2'd3;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_ODD  = 2'd1,
    OP_EVEN = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LATTICE_SIZE       = 3'd0,
    CFG_LEFT_EDGE          = 3'd1,
    CFG_RIGHT_EDGE         = 3'd2,
    CFG_FITNESS_TYPE1      = 3'd3,
    CFG_FITNESS_TYPE2      = 3'd4,
    CFG_FITNESS_TYPE3      = 3'd5,
    CFG_MUTATION_THRESHOLD = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    op_e              opcode;
    logic [IdxW-1:0]  cell_index;
    logic             record_walls;
    logic [RandW-1:0] rand_select;
    logic [RandW-1:0] rand_mutate;
  } in_item_t;

  typedef struct packed {
    logic [TypeW-1:0]       new_type;
    logic                   left_wall_valid;
    logic signed [OffW-1:0] left_wall_offset;
    logic                   right_wall_valid;
    logic signed [OffW-1:0] right_wall_offset;
  } out_item_t;

  typedef struct packed {
    logic [SizeW-1:0] lattice_size;
    logic [IdxW-1:0]  left_edge;
    logic [IdxW-1:0]  right_edge;
    logic [FitW-1:0]  fitness_type1;
    logic [FitW-1:0]  fitness_type2;
    logic [FitW-1:0]  fitness_type3;
    logic [RandW-1:0] mutation_threshold;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic mem_read;
    logic mul;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/slcs_dp.sv =====
// Datapath of the lattice competition step: index reduction, lattice buffers and update.
module slcs_dp #(
  parameter int unsigned MAX_CELLS = slcs_pkg::DefMaxCells
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slcs_pkg::cfg_t       cfg_i,
  input  slcs_pkg::in_item_t   in_data_i,
  input  slcs_pkg::dp_cmd_t    cmd_i,
  output slcs_pkg::dp_status_t status_o,
  output slcs_pkg::out_item_t  out_data_o
);
  import slcs_pkg::*;

  localparam int unsigned AW       = $clog2(MAX_CELLS);
  localparam int unsigned SizeBits = $clog2(MAX_CELLS + 1);
  localparam int unsigned SW       = (SizeBits > SizeW) ? SizeBits : SizeW;
  localparam int unsigned ProdW    = RandW + FitW + 1;

  // Captured transaction and working registers.
  op_e               op_q;
  logic              rec_q;
  logic [RandW-1:0]  rsel_q;
  logic [RandW-1:0]  rmut_q;
  logic [IdxW-1:0]   dvd_q, dvd_d;
  logic [IdxW-1:0]   rem_q, rem_d;
  logic [SW-1:0]     size_q;
  logic [DivCntW-1:0] cnt_q;
  logic [TypeW-1:0]  self_q;
  logic [TypeW-1:0]  other_q;
  logic [ProdW-1:0]  prod_q;
  logic [FitW-1:0]   gs_q;
  out_item_t         out_q, out_d;

  // Lattice buffers.
  logic [TypeW-1:0]  even_mem [MAX_CELLS];
  logic [TypeW-1:0]  odd_mem  [MAX_CELLS];

  logic [SW-1:0]     size_ext;
  logic [SW-1:0]     size_sat;
  logic [SW-1:0]     trial;
  logic [SW-1:0]     p_ext;
  logic [SW-1:0]     nb_ext;
  logic [AW-1:0]     p_addr;
  logic [AW-1:0]     nb_addr;
  logic [FitW:0]     fit_sum;
  logic [TypeW-1:0]  wr_type;
  logic              wr_even;
  logic              wr_odd;

  function automatic logic [FitW-1:0] fit_of(input cfg_t cfg, input logic [TypeW-1:0] t);
    logic [FitW-1:0] f;
    f = '0;
    if (t == TYPE_1) f = cfg.fitness_type1;
    if (t == TYPE_2) f = cfg.fitness_type2;
    if (t == TYPE_3) f = cfg.fitness_type3;
    return f;
  endfunction

  // Size in use, clamped to the supported range.
  always_comb begin
    size_ext = SW'(cfg_i.lattice_size);
    if (size_ext < SW'(MinCells)) begin
      size_sat = SW'(MinCells);
    end else if (size_ext > SW'(MAX_CELLS)) begin
      size_sat = SW'(MAX_CELLS);
    end else begin
      size_sat = size_ext;
    end
  end

  // Restoring division step: takes in the next index bit, subtracts the size if it fits.
  always_comb begin
    trial = SW'({rem_q, dvd_q[IdxW-1]});
    dvd_d = {dvd_q[IdxW-2:0], 1'b0};
    if (trial >= size_q) begin
      rem_d = IdxW'(trial - size_q);
    end else begin
      rem_d = IdxW'(trial);
    end
  end

  assign status_o.div_done = (cnt_q == DivCntW'(DivSteps - 1));

  // Step counter for the division.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  // Capture of the transaction and the iterative remainder.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_data_i.opcode;
      rec_q  <= in_data_i.record_walls;
      rsel_q <= in_data_i.rand_select;
      rmut_q <= in_data_i.rand_mutate;
      dvd_q  <= in_data_i.cell_index;
      rem_q  <= '0;
      size_q <= size_sat;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // Neighbour position on the ring: left for odd half-steps, right for even ones.
  always_comb begin
    p_ext = SW'(rem_q);
    if (op_q == OP_ODD) begin
      nb_ext = (p_ext == '0) ? size_q - SW'(1) : p_ext - SW'(1);
    end else begin
      nb_ext = (p_ext + SW'(1) == size_q) ? '0 : p_ext + SW'(1);
    end
    p_addr  = AW'(rem_q);
    nb_addr = AW'(nb_ext);
  end

  // Buffer reads: odd half-steps read the even copy, even half-steps the odd copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_read) begin
      if (op_q == OP_EVEN) begin
        self_q  <= odd_mem[p_addr];
        other_q <= odd_mem[nb_addr];
      end else begin
        self_q  <= even_mem[p_addr];
        other_q <= even_mem[nb_addr];
      end
    end
  end

  // Competition product r * (gs + gn).
  assign fit_sum = (FitW + 1)'(fit_of(cfg_i, self_q)) + (FitW + 1)'(fit_of(cfg_i, other_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(rsel_q) * ProdW'(fit_sum);
      gs_q   <= fit_of(cfg_i, self_q);
    end
  end

  // Result of the transaction: new type, wall positions and the buffer to write.
  always_comb begin
    logic [TypeW-1:0] upd;
    logic [TypeW-1:0] lt;
    logic [TypeW-1:0] rt;
    logic [OffW-1:0]  base;
    logic             differ;
    differ  = (self_q != other_q);
    lt      = (op_q == OP_ODD) ? other_q : self_q;
    rt      = (op_q == OP_ODD) ? self_q : other_q;
    base    = (op_q == OP_ODD) ? OffW'(rem_q) - OffW'(1) : OffW'(rem_q);
    upd     = self_q;
    if (differ && !(prod_q < ProdW'(gs_q))) begin
      upd = other_q;
    end
    if (upd == TYPE_2 && rmut_q < cfg_i.mutation_threshold) begin
      upd = TYPE_3;
    end
    out_d   = '0;
    wr_even = 1'b0;
    wr_odd  = 1'b0;
    wr_type = upd;
    unique case (op_q)
      OP_INIT: begin
        wr_type = (rem_q > cfg_i.left_edge && rem_q <= cfg_i.right_edge) ? TYPE_2 : TYPE_1;
        wr_even = 1'b1;
        out_d.new_type = wr_type;
      end
      OP_ODD, OP_EVEN: begin
        wr_even = (op_q == OP_EVEN);
        wr_odd  = (op_q == OP_ODD);
        out_d.new_type = upd;
        if (rec_q && differ && lt == TYPE_1) begin
          out_d.left_wall_valid  = 1'b1;
          out_d.left_wall_offset = base - OffW'(cfg_i.left_edge);
        end
        if (rec_q && differ && rt == TYPE_1) begin
          out_d.right_wall_valid  = 1'b1;
          out_d.right_wall_offset = base - OffW'(cfg_i.right_edge);
        end
      end
      default: begin
        out_d.new_type = self_q;
      end
    endcase
  end

  // Buffer write and output register on commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
      if (wr_even) begin
        even_mem[p_addr] <= wr_type;
      end
      if (wr_odd) begin
        odd_mem[p_addr] <= wr_type;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/slcs_ctrl.sv =====
// Controller state machine of the lattice competition step.
`include "stochastic_lattice_competition_step_macros.svh"
module slcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  slcs_pkg::dp_status_t status_i,
  output slcs_pkg::dp_cmd_t    cmd_o
);
  import slcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_MUL,
    S_WB
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.mem_read = (state_q == S_READ);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.commit   = (state_q == S_WB) && slot_free;
  end

  // Next state and output valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_WB;
      end
      S_WB: begin
        if (slot_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A new result appears only from the write-back state.
  `SLCS_ASSERT_IMP(a_out_from_wb, $rose(out_valid_o), $past(state_q) == S_WB)
  // The result register is never overwritten while a result waits.
  `SLCS_ASSERT_IMP(a_commit_free, cmd_o.commit, !out_valid_q || out_ready_i)
  // An accepted transaction always starts the index reduction.
  `SLCS_ASSERT_NXT(a_accept_div, in_valid_i && in_ready_o, state_q == S_DIV)
  // The reduction runs until the datapath reports its last step.
  `SLCS_ASSERT_NXT(a_div_hold, state_q == S_DIV && !status_i.div_done, state_q == S_DIV)

endmodule

// ===== rtl/stochastic_lattice_competition_step.sv =====
// Top level of the lattice competition step: ports, configuration registers, controller and datapath.
// A result becomes valid after its write-back, which waits while the output register still holds a result.
// Transactions are taken one at a time: each passes through the ten-step remainder unit that reduces
// the cell index modulo the lattice size, then read, multiply and write-back, before the next is taken.
// A new transaction is taken while the previous result still waits at the output register.
// Reset (rst_ni, asynchronous, active low) clears control state and loads register defaults;
// the lattice buffers are not cleared and hold undefined data until written.
`include "stochastic_lattice_competition_step_macros.svh"
module stochastic_lattice_competition_step #(
  parameter int unsigned MAX_CELLS = slcs_pkg::DefMaxCells
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [slcs_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  slcs_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output slcs_pkg::out_item_t             out_data_o
);
  import slcs_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lattice_size       <= RstLatticeSize;
      cfg_q.left_edge          <= RstLeftEdge;
      cfg_q.right_edge         <= RstRightEdge;
      cfg_q.fitness_type1      <= RstFitness1;
      cfg_q.fitness_type2      <= RstFitness2;
      cfg_q.fitness_type3      <= RstFitness3;
      cfg_q.mutation_threshold <= RstMutThresh;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LATTICE_SIZE:       cfg_q.lattice_size       <= cfg_data_i[SizeW-1:0];
        CFG_LEFT_EDGE:          cfg_q.left_edge          <= cfg_data_i[IdxW-1:0];
        CFG_RIGHT_EDGE:         cfg_q.right_edge         <= cfg_data_i[IdxW-1:0];
        CFG_FITNESS_TYPE1:      cfg_q.fitness_type1      <= cfg_data_i[FitW-1:0];
        CFG_FITNESS_TYPE2:      cfg_q.fitness_type2      <= cfg_data_i[FitW-1:0];
        CFG_FITNESS_TYPE3:      cfg_q.fitness_type3      <= cfg_data_i[FitW-1:0];
        CFG_MUTATION_THRESHOLD: cfg_q.mutation_threshold <= cfg_data_i[RandW-1:0];
        default: begin
        end
      endcase
    end
  end

  slcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  slcs_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
